// File: rtl/core/mmpp_pkg.sv
// Shared types and constants of the min/max peak pyramid.
package mmpp_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int PEAK_MAX_W  = 15;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [PEAK_MAX_W-1:0]      peak_max_t;

	// One closed level-0 group on its way to the level cascade.
	typedef struct packed {
		logic      flush;
		peak_max_t peak_max;
		sample_t   peak_min;
	} entry_t;

endpackage

// File: rtl/core/mmpp_front.sv
// Front end: accepts frames and folds them into level-0 groups.
module mmpp_front
	import mmpp_pkg::*;
#(
	parameter int BASE_GROUP = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tvalid,
	output logic                 tready,
	input  logic [IN_DATA_W-1:0] tdata,
	input  logic [0:0]           tuser,
	input  logic                 tlast,
	input  logic                 q_ready,
	output logic                 push,
	output entry_t               push_entry
);

	localparam int BCNT_W = $clog2(BASE_GROUP);

	sample_t           base_min_q;
	peak_max_t         base_max_q;
	logic [BCNT_W-1:0] base_cnt_q;

	sample_t   left_s;
	sample_t   right_s;
	peak_max_t left_pos;
	peak_max_t right_pos;
	sample_t   min_a;
	sample_t   min_b;
	peak_max_t max_a;
	peak_max_t max_b;
	logic      accept;
	logic      close;

	always_comb begin
		left_s    = sample_t'(tdata[SAMPLE_W-1:0]);
		right_s   = sample_t'(tdata[2*SAMPLE_W-1:SAMPLE_W]);
		// negative samples never raise a max seeded at zero
		left_pos  = left_s[SAMPLE_W-1] ? '0 : left_s[PEAK_MAX_W-1:0];
		right_pos = right_s[SAMPLE_W-1] ? '0 : right_s[PEAK_MAX_W-1:0];
		min_a     = (left_s < base_min_q) ? left_s : base_min_q;
		min_b     = (right_s < min_a) ? right_s : min_a;
		max_a     = (left_pos > base_max_q) ? left_pos : base_max_q;
		max_b     = (right_pos > max_a) ? right_pos : max_a;
		accept    = tvalid && q_ready;
		close     = (base_cnt_q == BCNT_W'(BASE_GROUP - 1)) || tuser[0] || tlast;
	end

	assign tready     = q_ready;
	assign push       = accept && close;
	assign push_entry = '{flush: tlast, peak_max: max_b, peak_min: min_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_min_q <= '0;
			base_max_q <= '0;
			base_cnt_q <= '0;
		end else if (accept) begin
			if (close) begin
				base_min_q <= '0;
				base_max_q <= '0;
				base_cnt_q <= '0;
			end else begin
				base_min_q <= min_b;
				base_max_q <= max_b;
				base_cnt_q <= base_cnt_q + BCNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/core/mmpp_queue.sv
// Short queue of closed level-0 groups between front and back.
module mmpp_queue
	import mmpp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   ready,
	output entry_t head,
	output logic   head_valid,
	input  logic   pop
);

	entry_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign ready      = (fill_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + (QPTR_W+1)'(1);
				2'b01:   fill_q <= fill_q - (QPTR_W+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// File: rtl/core/mmpp_back.sv
// Back end: walks one queued group up the level cascade, one word per cycle while the output is not stalled.
module mmpp_back
	import mmpp_pkg::*;
#(
	parameter int FANOUT       = 8,
	parameter int UPPER_LEVELS = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  entry_t                              head,
	input  logic                                head_valid,
	output logic                                pop,
	output logic                                tvalid,
	input  logic                                tready,
	output logic [OUT_DATA_W-1:0]               tdata,
	output logic [$clog2(UPPER_LEVELS+1)-1:0]   tuser,
	output logic                                tlast
);

	localparam int LVL_W = $clog2(UPPER_LEVELS + 1);
	localparam int CNT_W = $clog2(FANOUT);
	localparam int PAD_W = OUT_DATA_W - PEAK_MAX_W - SAMPLE_W;

	// accumulator j builds the groups of level j+1
	sample_t          acc_min_q [UPPER_LEVELS];
	peak_max_t        acc_max_q [UPPER_LEVELS];
	logic [CNT_W-1:0] acc_cnt_q [UPPER_LEVELS];
	logic             has8_q    [UPPER_LEVELS];

	logic [LVL_W-1:0] lvl_q;

	logic             out_valid_q;
	logic [LVL_W-1:0] out_lvl_q;
	sample_t          out_min_q;
	peak_max_t        out_max_q;
	logic             out_last_q;

	logic                  step;
	logic [UPPER_LEVELS:0] emit;
	logic                  inc;
	logic                  full;
	logic                  last;
	logic [LVL_W-1:0]      nxt;
	sample_t               sel_min;
	peak_max_t             sel_max;

	assign step = head_valid && (!out_valid_q || tready);
	assign pop  = step && last;

	// Predict which levels above the current one still emit for this group.
	// Emission depends only on counts and flags, never on sample values.
	always_comb begin
		emit = '0;
		inc  = 1'b0;
		full = 1'b0;
		for (int j = 0; j < UPPER_LEVELS; j++) begin
			inc  = (LVL_W'(j) == lvl_q) || ((LVL_W'(j) > lvl_q) && emit[j]);
			full = inc && (acc_cnt_q[j] == CNT_W'(FANOUT - 1));
			emit[j+1] = (LVL_W'(j) >= lvl_q) && (full || (head.flush
				&& (has8_q[j] || full) && ((acc_cnt_q[j] != '0) || inc)));
		end
	end

	// lowest emitting level above the current one
	always_comb begin
		last = 1'b1;
		nxt  = '0;
		for (int j = UPPER_LEVELS; j >= 1; j--) begin
			if (emit[j]) begin
				last = 1'b0;
				nxt  = LVL_W'(j);
			end
		end
	end

	// level 0 comes straight from the queue, higher levels from their accumulator
	always_comb begin
		sel_min = head.peak_min;
		sel_max = head.peak_max;
		for (int j = 0; j < UPPER_LEVELS; j++) begin
			if (lvl_q == LVL_W'(j + 1)) begin
				sel_min = acc_min_q[j];
				sel_max = acc_max_q[j];
			end
		end
	end

	// Drain the emitting accumulator, fold the word into the one above,
	// clear everything on the last word of a stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < UPPER_LEVELS; j++) begin
				acc_min_q[j] <= '0;
				acc_max_q[j] <= '0;
				acc_cnt_q[j] <= '0;
				has8_q[j]    <= 1'b0;
			end
		end else if (step) begin
			for (int j = 0; j < UPPER_LEVELS; j++) begin
				priority if (last && head.flush) begin
					acc_min_q[j] <= '0;
					acc_max_q[j] <= '0;
					acc_cnt_q[j] <= '0;
					has8_q[j]    <= 1'b0;
				end else if (lvl_q == LVL_W'(j + 1)) begin
					acc_min_q[j] <= '0;
					acc_max_q[j] <= '0;
					acc_cnt_q[j] <= '0;
				end else if (lvl_q == LVL_W'(j)) begin
					acc_min_q[j] <= (sel_min < acc_min_q[j]) ? sel_min : acc_min_q[j];
					acc_max_q[j] <= (sel_max > acc_max_q[j]) ? sel_max : acc_max_q[j];
					if (acc_cnt_q[j] == CNT_W'(FANOUT - 1)) begin
						acc_cnt_q[j] <= '0;
						has8_q[j]    <= 1'b1;
					end else begin
						acc_cnt_q[j] <= acc_cnt_q[j] + CNT_W'(1);
					end
				end else begin
					acc_cnt_q[j] <= acc_cnt_q[j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				lvl_q <= last ? '0 : nxt;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_lvl_q  <= lvl_q;
			out_min_q  <= sel_min;
			out_max_q  <= sel_max;
			out_last_q <= last;
		end
	end

	assign tvalid = out_valid_q;
	assign tdata  = {{PAD_W{1'b0}}, out_max_q, out_min_q};
	assign tuser  = out_lvl_q;
	assign tlast  = out_last_q;

endmodule

// File: rtl/core/minmax_peak_pyramid.sv
// Top level of the min/max peak pyramid: front end, group queue, level cascade.
//
//  channel  | direction | tdata                          | tuser      | tlast
//  ---------+-----------+--------------------------------+------------+-----------
//  s_axis   | in        | left_sample, right_sample      | chunk_end  | stream_end
//  m_axis   | out       | peak_min, peak_max, zero pad   | level      | run_last
//
// The front end takes one frame word per cycle while the group queue has room.
// Each closed level-0 group keeps the back end busy for its result words (1 to
// UPPER_LEVELS+1 words); the back end emits one word per cycle unless m_axis stalls.
// Reset is asynchronous and clears every accumulator at once; no clearing pass.
// A stall on m_axis holds the output register; the queue (four groups) absorbs
// it until full, then s_axis_tready drops.
module minmax_peak_pyramid
	import mmpp_pkg::*;
#(
	parameter int BASE_GROUP   = 32,
	parameter int FANOUT       = 8,
	parameter int UPPER_LEVELS = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [15:0] left_sample, [31:16] right_sample
	input  logic [IN_DATA_W-1:0]              s_axis_tdata,
	// [0] chunk_end
	input  logic [0:0]                        s_axis_tuser,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [15:0] peak_min, [30:16] peak_max, [31] zero
	output logic [OUT_DATA_W-1:0]             m_axis_tdata,
	// level
	output logic [$clog2(UPPER_LEVELS+1)-1:0] m_axis_tuser,
	output logic                              m_axis_tlast
);

	// front to queue
	logic   push;
	entry_t push_entry;
	logic   q_ready;

	// queue to back
	entry_t head;
	logic   head_valid;
	logic   pop;

	// Fold frames into level-0 groups; hand each closed group to the queue.
	mmpp_front #(
		.BASE_GROUP(BASE_GROUP)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.tvalid    (s_axis_tvalid),
		.tready    (s_axis_tready),
		.tdata     (s_axis_tdata),
		.tuser     (s_axis_tuser),
		.tlast     (s_axis_tlast),
		.q_ready   (q_ready),
		.push      (push),
		.push_entry(push_entry)
	);

	// Decouple frame intake from the multi-word cascade walk.
	mmpp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.ready     (q_ready),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop)
	);

	// Walk each group up the levels and drive the result words.
	mmpp_back #(
		.FANOUT      (FANOUT),
		.UPPER_LEVELS(UPPER_LEVELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.tvalid    (m_axis_tvalid),
		.tready    (m_axis_tready),
		.tdata     (m_axis_tdata),
		.tuser     (m_axis_tuser),
		.tlast     (m_axis_tlast)
	);

endmodule

// File: tb/sv/tb_minmax_peak_pyramid.sv
// Self-checking testbench for the min/max peak pyramid: frame stimulus, cascade predictor, checker.
module tb_minmax_peak_pyramid
	import mmpp_pkg::*;
;

	localparam int BASE_GROUP     = 32;
	localparam int FANOUT         = 8;
	localparam int UPPER_LEVELS   = 5;
	localparam int LEVEL_W        = $clog2(UPPER_LEVELS + 1);
	localparam int RESET_CYCLES   = 7;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 64;
	localparam int PRINT_LIMIT    = 40;
	// Enough chunk-closed frames to fill level 2 once and leave partial groups
	// on levels 1 and 2: 8^2 + 8 + 3.
	localparam int DEEP_FRAMES    = 75;

	typedef struct packed {
		sample_t left;
		sample_t right;
		logic    chunk_end;
		logic    stream_end;
	} frame_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		sample_t            lo;
		peak_max_t          hi;
		logic               last;
	} peak_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [0:0]            s_axis_tuser = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [LEVEL_W-1:0]    m_axis_tuser;
	logic                  m_axis_tlast;

	// Predictor state: level-0 accumulator and one accumulator per upper level.
	int          base_lo;
	int          base_hi;
	int          base_count;
	int          lvl_lo [UPPER_LEVELS];
	int          lvl_hi [UPPER_LEVELS];
	int          lvl_count [UPPER_LEVELS];
	bit          lvl_src_full [UPPER_LEVELS];
	peak_t       frame_peaks [$];
	peak_t       pending_peaks [$];

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          err_count = 0;
	int          frames_sent = 0;
	int          peaks_checked = 0;
	int          deepest_level = 0;
	int          idle_cycles = 0;

	minmax_peak_pyramid #(
		.BASE_GROUP   (BASE_GROUP),
		.FANOUT       (FANOUT),
		.UPPER_LEVELS (UPPER_LEVELS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void clear_pyramid();
		base_lo    = 0;
		base_hi    = 0;
		base_count = 0;
		for (int k = 0; k < UPPER_LEVELS; k++) begin
			lvl_lo[k]       = 0;
			lvl_hi[k]       = 0;
			lvl_count[k]    = 0;
			lvl_src_full[k] = 1'b0;
		end
	endfunction

	function automatic void emit_peak(input int lvl, input int lo, input int hi);
		peak_t p;
		p.level = LEVEL_W'(lvl);
		p.lo    = SAMPLE_W'(lo);
		p.hi    = PEAK_MAX_W'(hi);
		p.last  = 1'b0;
		frame_peaks = {frame_peaks, p};
	endfunction

	// Fold one entry of level j into the accumulator above it; ripple up on a full group.
	function automatic void carry_up(input int j, input int lo, input int hi);
		int lvl;
		int cur_lo;
		int cur_hi;
		lvl    = j;
		cur_lo = lo;
		cur_hi = hi;
		while (lvl < UPPER_LEVELS) begin
			if (cur_lo < lvl_lo[lvl])
				lvl_lo[lvl] = cur_lo;
			if (cur_hi > lvl_hi[lvl])
				lvl_hi[lvl] = cur_hi;
			lvl_count[lvl]++;
			if (lvl_count[lvl] < FANOUT)
				return;
			lvl_src_full[lvl] = 1'b1;
			cur_lo = lvl_lo[lvl];
			cur_hi = lvl_hi[lvl];
			lvl_lo[lvl]    = 0;
			lvl_hi[lvl]    = 0;
			lvl_count[lvl] = 0;
			emit_peak(lvl + 1, cur_lo, cur_hi);
			lvl++;
		end
	endfunction

	// Advance the predicted pyramid by one accepted frame; queue the words it causes.
	function automatic void fold_frame(input frame_t f);
		int    l;
		int    r;
		int    lo;
		int    hi;
		int    n;
		peak_t p;
		l = f.left;
		r = f.right;
		if (l < base_lo) base_lo = l;
		if (r < base_lo) base_lo = r;
		if (l > base_hi) base_hi = l;
		if (r > base_hi) base_hi = r;
		base_count++;
		if (base_count >= BASE_GROUP || f.chunk_end || f.stream_end) begin
			lo = base_lo;
			hi = base_hi;
			base_lo    = 0;
			base_hi    = 0;
			base_count = 0;
			emit_peak(0, lo, hi);
			carry_up(0, lo, hi);
		end
		if (f.stream_end) begin
			// Flush partial groups bottom-up; a level exists only if its source filled once.
			for (int j = 0; j < UPPER_LEVELS; j++) begin
				if (lvl_count[j] > 0 && lvl_src_full[j]) begin
					lo = lvl_lo[j];
					hi = lvl_hi[j];
					lvl_lo[j]    = 0;
					lvl_hi[j]    = 0;
					lvl_count[j] = 0;
					emit_peak(j + 1, lo, hi);
					carry_up(j + 1, lo, hi);
				end
			end
			clear_pyramid();
		end
		n = frame_peaks.size();
		for (int i = 0; i < n; i++) begin
			p      = frame_peaks[i];
			p.last = (i == n - 1);
			pending_peaks = {pending_peaks, p};
		end
		frame_peaks.delete();
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= PRINT_LIMIT)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		peak_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			peaks_checked++;
			if (int'(m_axis_tuser) > deepest_level)
				deepest_level = int'(m_axis_tuser);
			if (pending_peaks.size() == 0) begin
				report_mismatch($sformatf("unexpected word level=%0d data=%h",
					m_axis_tuser, m_axis_tdata));
			end else begin
				want = pending_peaks.pop_front();
				if (m_axis_tuser !== want.level)
					report_mismatch($sformatf("level got %0d want %0d",
						m_axis_tuser, want.level));
				if (m_axis_tdata[15:0] !== want.lo)
					report_mismatch($sformatf("peak_min got %0d want %0d (level %0d)",
						$signed(m_axis_tdata[15:0]), want.lo, want.level));
				if (m_axis_tdata[30:16] !== want.hi)
					report_mismatch($sformatf("peak_max got %0d want %0d (level %0d)",
						m_axis_tdata[30:16], want.hi, want.level));
				if (m_axis_tdata[31] !== 1'b0)
					report_mismatch("pad bit of tdata is not zero");
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("run_last got %b want %b (level %0d)",
						m_axis_tlast, want.last, want.level));
			end
		end
	end

	// Drop the run when no word moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no word moved for %0d cycles, %0d still expected",
				idle_cycles, pending_peaks.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver back-pressure.
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// ---------------------------------------------------------------- stimulus

	function automatic frame_t make_frame(input sample_t l, input sample_t r,
		input logic ce, input logic se);
		frame_t f;
		f.left       = l;
		f.right      = r;
		f.chunk_end  = ce;
		f.stream_end = se;
		return f;
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(7))
			0:       return 16'sh8000;
			1:       return 16'sh7fff;
			2:       return '0;
			3:       return SAMPLE_W'(int'($urandom_range(16)) - 8);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Send one frame word; called and returning at a falling edge. Valid stays high
	// into the next call unless that call rolls an idle cycle.
	task automatic send_frame(input frame_t f);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= $urandom;
			s_axis_tuser  <= 1'($urandom_range(1));
			s_axis_tlast  <= 1'($urandom_range(1));
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {f.right, f.left};
		s_axis_tuser  <= f.chunk_end;
		s_axis_tlast  <= f.stream_end;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		fold_frame(f);
		frames_sent++;
		@(negedge clk);
	endtask

	task automatic set_idle(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	// Extremes, bit patterns, one-sided groups, level-1 fill, flush and drop rules.
	task automatic test_directed_edges();
		send_frame(make_frame(16'sh8000, 16'sh7fff, 1'b1, 1'b0));
		send_frame(make_frame(16'sh7fff, 16'sh8000, 1'b1, 1'b0));
		send_frame(make_frame(16'sh0000, 16'sh0000, 1'b1, 1'b0));
		send_frame(make_frame(16'sh5555, 16'shaaaa, 1'b1, 1'b0));
		send_frame(make_frame(16'shaaaa, 16'sh5555, 1'b1, 1'b0));
		send_frame(make_frame(-16'sd1, 16'sd1, 1'b1, 1'b0));
		// Positive-only and negative-only groups keep the zero seed on the other side.
		send_frame(make_frame(16'sd100, 16'sd200, 1'b1, 1'b0));
		// Eighth level-0 entry fills level 1.
		send_frame(make_frame(-16'sd5, -16'sd7, 1'b1, 1'b0));
		send_frame(make_frame(16'sd3, 16'sd4, 1'b0, 1'b0));
		// Chunk end with stream end: close level 0 once, flush level 1, drop level 2.
		send_frame(make_frame(16'sd1, -16'sd1, 1'b1, 1'b1));
		// Short stream: level 1 partial is dropped since level 0 never filled it.
		send_frame(make_frame(16'sd5, 16'sd5, 1'b1, 1'b0));
		send_frame(make_frame(16'sd6, -16'sd6, 1'b0, 1'b1));
		// Stream end alone on a single frame.
		send_frame(make_frame(16'sd7, -16'sd7, 1'b0, 1'b1));
		// Full level-0 group with no chunk end, then a partial one closed by a chunk end.
		for (int k = 0; k < BASE_GROUP + 3; k++)
			send_frame(make_frame(16'(k * 97), -16'(k * 31), k == BASE_GROUP + 2, 1'b0));
		send_frame(make_frame(16'sh7fff, 16'sh8000, 1'b0, 1'b1));
	endtask

	// Streams with random chunk density, mostly well-formed, some short noisy bursts.
	task automatic test_random_streams(input int n_frames);
		int     sent;
		int     span;
		int     ce_pct;
		bit     noisy;
		bit     closes;
		frame_t f;
		sent = 0;
		while (sent < n_frames) begin
			noisy = ($urandom_range(9) == 0);
			span  = noisy ? $urandom_range(1, 4) : $urandom_range(8, 80);
			if (span > n_frames - sent)
				span = n_frames - sent;
			case ($urandom_range(3))
				0:       ce_pct = 0;
				1:       ce_pct = 12;
				2:       ce_pct = 50;
				default: ce_pct = 100;
			endcase
			closes = ($urandom_range(3) != 0);
			for (int k = 0; k < span; k++) begin
				f.left       = pick_sample();
				f.right      = pick_sample();
				f.chunk_end  = ($urandom_range(99) < ce_pct);
				f.stream_end = noisy ? 1'($urandom_range(1)) : (closes && k == span - 1);
				send_frame(f);
			end
			sent += span;
		end
	endtask

	// Hold the sender until every expected word has come back.
	task automatic test_drain_pause();
		repeat (4)
			send_frame(make_frame(pick_sample(), pick_sample(), 1'b1, 1'b0));
		s_axis_tvalid <= 1'b0;
		while (pending_peaks.size() != 0)
			@(negedge clk);
	endtask

	// One stream that reaches level 2, flushes partial groups on levels 1 and 2
	// and drops the one on level 3.
	task automatic test_full_pyramid();
		int span;
		for (int k = 0; k < DEEP_FRAMES; k++) begin
			span = k / 4;
			send_frame(make_frame(SAMPLE_W'($urandom_range(span)),
				-SAMPLE_W'($urandom_range(span)), 1'b1, 1'b0));
		end
		send_frame(make_frame(pick_sample(), pick_sample(), 1'b0, 1'b1));
	endtask

	initial begin
		clear_pyramid();
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idle(25, 68);
		test_directed_edges();
		test_random_streams(45);
		test_drain_pause();
		set_idle(68, 25);
		test_random_streams(45);
		set_idle(0, 0);
		test_random_streams(40);
		test_full_pyramid();

		s_axis_tvalid <= 1'b0;
		while (pending_peaks.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Sent %0d frames and checked %0d peak words up to level %0d,",
			frames_sent, peaks_checked, deepest_level);
		$display("under sender-heavy, receiver-heavy and stall-free pacing; %0d mismatches.",
			err_count);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
